// File: rtl/rgbhsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbhsl_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned SUM_W     = CH_W + 1;
  localparam int unsigned HDIV_W    = CH_W + 3;
  localparam int unsigned QUOT_W    = 16;
  localparam int unsigned DIV_STEPS = 2;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef enum logic [1:0] {
    SEG_RED,
    SEG_RED_WRAP,
    SEG_GREEN,
    SEG_BLUE
  } seg_t;

endpackage

`default_nettype wire

// File: rtl/rgb_to_hsl_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// RGB to HSL converter, unsigned 0.16 fixed point outputs.
// Request channel: red/green/blue are taken at a rising edge with start high
// and busy low. busy is only high while reset is in progress, so a new pixel
// may be issued on every clock.
// Result channel: hue/saturation/lightness are valid for exactly one cycle
// while done is high; there is no back-pressure from the receiver.
// Throughput is one pixel per clock.
// Pipeline: channel max/min and segment select, then numerator, divisor and
// lightness, then 16/DIV_STEPS restoring-division stages that produce
// DIV_STEPS bits of the hue and saturation fractions each, then the output
// register with grey/full-scale overrides.
// Reset clears every valid bit; requests in flight are dropped.
module rgb_to_hsl_converter_core
  import rgbhsl_pkg::*;
#(
  parameter int unsigned DIV_STEPS_P = DIV_STEPS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [CH_W-1:0]  red,
  input  wire logic [CH_W-1:0]  green,
  input  wire logic [CH_W-1:0]  blue,
  output logic                  done,
  output logic [OUT_W-1:0]      hue,
  output logic [OUT_W-1:0]      saturation,
  output logic [OUT_W-1:0]      lightness
);

  localparam int unsigned NSTAGE = QUOT_W / DIV_STEPS_P;

  logic in_acc;
  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // stage 1: max/min and segment
  logic            s1_valid;
  logic [CH_W-1:0] s1_r, s1_g, s1_b, s1_mx, s1_mn;
  seg_t            s1_seg;
  logic [CH_W-1:0] mx_next, mn_next;
  seg_t            seg_next;

  always_comb begin
    mx_next = red;
    mn_next = red;
    if (green > mx_next) mx_next = green;
    if (blue > mx_next) mx_next = blue;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next) mn_next = blue;
    if (mx_next == red) begin
      seg_next = (green < blue) ? SEG_RED_WRAP : SEG_RED;
    end else if (mx_next == green) begin
      seg_next = SEG_GREEN;
    end else begin
      seg_next = SEG_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
    s1_r   <= red;
    s1_g   <= green;
    s1_b   <= blue;
    s1_mx  <= mx_next;
    s1_mn  <= mn_next;
    s1_seg <= seg_next;
  end

  // stage 2: operands
  logic [CH_W-1:0]   d;
  logic [SUM_W-1:0]  sm;
  logic [CH_W-1:0]   den;
  logic [HDIV_W-1:0] segd, hdiv_next;
  logic signed [HDIV_W:0] n_s, num_s;
  logic [OUT_W-1:0]  ly;
  logic [OUT_W:0]    lq, lsum;
  logic [OUT_W-1:0]  light_next;

  always_comb begin
    d  = s1_mx - s1_mn;
    sm = {1'b0, s1_mx} + {1'b0, s1_mn};
    if (sm <= SUM_W'(255)) begin
      den = sm[CH_W-1:0];
    end else begin
      den = CH_W'(SUM_W'(510) - sm);
    end
    hdiv_next = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
    case (s1_seg)
      SEG_RED: begin
        segd = '0;
        n_s  = $signed({4'b0, s1_g}) - $signed({4'b0, s1_b});
      end
      SEG_RED_WRAP: begin
        segd = hdiv_next;
        n_s  = $signed({4'b0, s1_g}) - $signed({4'b0, s1_b});
      end
      SEG_GREEN: begin
        segd = {2'b00, d, 1'b0};
        n_s  = $signed({4'b0, s1_b}) - $signed({4'b0, s1_r});
      end
      SEG_BLUE: begin
        segd = {1'b0, d, 2'b00};
        n_s  = $signed({4'b0, s1_r}) - $signed({4'b0, s1_g});
      end
      default: begin
        segd = '0;
        n_s  = '0;
      end
    endcase
    num_s = $signed({1'b0, segd}) + n_s;
    // sm*32768/255 = 128*sm + floor(128*sm/255)
    ly   = {sm, 7'b0};
    lq   = ({1'b0, ly} + {9'b0, ly[OUT_W-1:8]} + (OUT_W+1)'(1)) >> 8;
    lsum = {1'b0, ly} + lq;
    light_next = lsum[OUT_W] ? OUT_MAX : lsum[OUT_W-1:0];
  end

  logic [NSTAGE:0]   v;
  logic [HDIV_W-1:0] hrem [0:NSTAGE];
  logic [HDIV_W-1:0] hdiv [0:NSTAGE];
  logic [QUOT_W-1:0] hq   [0:NSTAGE];
  logic [CH_W-1:0]   srem [0:NSTAGE];
  logic [CH_W-1:0]   sden [0:NSTAGE];
  logic [QUOT_W-1:0] sq   [0:NSTAGE];
  logic [NSTAGE:0]   grey;
  logic [NSTAGE:0]   full;
  logic [OUT_W-1:0]  light [0:NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= s1_valid;
    end
    hrem[0]  <= num_s[HDIV_W-1:0];
    hdiv[0]  <= hdiv_next;
    hq[0]    <= '0;
    srem[0]  <= d;
    sden[0]  <= den;
    sq[0]    <= '0;
    grey[0]  <= (d == '0);
    full[0]  <= (d == den);
    light[0] <= light_next;
  end

  // restoring division stages, fractional quotient bits
  for (genvar k = 0; k < NSTAGE; k++) begin : g_div
    logic [HDIV_W-1:0]      hr;
    logic [CH_W-1:0]        sr;
    logic [DIV_STEPS_P-1:0] hb, sb;

    always_comb begin : c_step
      logic [HDIV_W:0] ht;
      logic [CH_W:0]   st;
      hr = hrem[k];
      sr = srem[k];
      hb = '0;
      sb = '0;
      for (int j = 0; j < DIV_STEPS_P; j++) begin
        ht = {hr, 1'b0};
        if (ht >= {1'b0, hdiv[k]}) begin
          hb[DIV_STEPS_P-1-j] = 1'b1;
          ht = ht - {1'b0, hdiv[k]};
        end
        hr = ht[HDIV_W-1:0];
        st = {sr, 1'b0};
        if (st >= {1'b0, sden[k]}) begin
          sb[DIV_STEPS_P-1-j] = 1'b1;
          st = st - {1'b0, sden[k]};
        end
        sr = st[CH_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      hrem[k+1]  <= hr;
      hdiv[k+1]  <= hdiv[k];
      hq[k+1]    <= {hq[k][QUOT_W-DIV_STEPS_P-1:0], hb};
      srem[k+1]  <= sr;
      sden[k+1]  <= sden[k];
      sq[k+1]    <= {sq[k][QUOT_W-DIV_STEPS_P-1:0], sb};
      grey[k+1]  <= grey[k];
      full[k+1]  <= full[k];
      light[k+1] <= light[k];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[NSTAGE];
    end
    lightness <= light[NSTAGE];
    if (grey[NSTAGE]) begin
      hue        <= '0;
      saturation <= '0;
    end else begin
      hue        <= hq[NSTAGE];
      saturation <= full[NSTAGE] ? OUT_MAX : sq[NSTAGE];
    end
  end

  localparam int unsigned LAT = NSTAGE + 3;

  a_done_from_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_acc, LAT))
    else $error("result without matching request");

  a_hue_implies_sat: assert property (@(posedge clk) disable iff (rst)
    (done && hue != '0) |-> saturation != '0)
    else $error("nonzero hue on grey pixel");

  a_sat_implies_light: assert property (@(posedge clk) disable iff (rst)
    (done && saturation != '0) |-> lightness != '0)
    else $error("saturation on black pixel");

  a_busy_only_reset: assert property (@(posedge clk)
    busy |-> $past(rst))
    else $error("busy outside reset");

endmodule

`default_nettype wire

// File: test/rgb_to_hsl_converter_core_test.sv
`timescale 1ns / 1ps

module rgb_to_hsl_converter_core_test;
  import rgbhsl_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 1100;
  localparam int unsigned PIPE_DEPTH    = 2 + 16 / DIV_STEPS + 1;

  typedef struct {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    int unsigned     gap;
    bit              drain;
  } pixel_req_t;

  typedef struct {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] saturation;
    logic [OUT_W-1:0] lightness;
  } hsl_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [CH_W-1:0]   red = '0;
  logic [CH_W-1:0]   green = '0;
  logic [CH_W-1:0]   blue = '0;
  logic              busy;
  logic              done;
  logic [OUT_W-1:0]  hue;
  logic [OUT_W-1:0]  saturation;
  logic [OUT_W-1:0]  lightness;

  pixel_req_t  pixel_req_q[$];
  hsl_t        hsl_due_q[$];
  int unsigned issued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned gap_left = 0;
  bit          gap_armed = 1'b0;
  int unsigned mismatch_cnt = 0;

  rgb_to_hsl_converter_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

  always #2 clk = ~clk;

  function automatic logic [OUT_W-1:0] clip16(input longint v);
    return (v > 65535) ? OUT_MAX : OUT_W'(v);
  endfunction

  function automatic hsl_t hsl_of_pixel(input logic [CH_W-1:0] r, g, b);
    hsl_t res;
    int   ri, gi, bi, mx, mn, d, sm, den, num;
    seg_t seg;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    d  = mx - mn;
    sm = mx + mn;
    res.lightness  = clip16(longint'(sm) * 32768 / 255);
    res.hue        = '0;
    res.saturation = '0;
    if (d != 0) begin
      den = (sm <= 255) ? sm : 510 - sm;
      res.saturation = clip16(longint'(d) * 65536 / den);
      if (mx == ri) seg = (gi < bi) ? SEG_RED_WRAP : SEG_RED;
      else if (mx == gi) seg = SEG_GREEN;
      else seg = SEG_BLUE;
      case (seg)
        SEG_RED:      num = gi - bi;
        SEG_RED_WRAP: num = 6 * d + gi - bi;
        SEG_GREEN:    num = 2 * d + bi - ri;
        default:      num = 4 * d + ri - gi;
      endcase
      if (num < 0) num = 0;
      res.hue = clip16(longint'(num) * 65536 / (6 * d));
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // driver: one request in flight on the port, next one follows its own gap
  always @(negedge clk) begin : drive
    logic nxt_start;
    nxt_start = start;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (start && taken_cnt == issued_cnt) nxt_start = 1'b0;
      if (!nxt_start && pixel_req_q.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = pixel_req_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (!(pixel_req_q[0].drain && hsl_due_q.size() != 0)) begin
          red   <= pixel_req_q[0].r;
          green <= pixel_req_q[0].g;
          blue  <= pixel_req_q[0].b;
          void'(pixel_req_q.pop_front());
          gap_armed = 1'b0;
          issued_cnt++;
          nxt_start = 1'b1;
        end
      end
    end
    start <= nxt_start;
  end

  // monitor: results first, then the request taken at this edge
  always @(posedge clk) begin : observe
    hsl_t want;
    if (!rst && done === 1'b1) begin
      if (hsl_due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result with nothing pending: hue %0d sat %0d light %0d",
                   $realtime, hue, saturation, lightness);
      end else begin
        want = hsl_due_q.pop_front();
        check_field("hue", want.hue, hue);
        check_field("saturation", want.saturation, saturation);
        check_field("lightness", want.lightness, lightness);
      end
    end
    if (!rst && start && busy === 1'b0) begin
      hsl_due_q.push_back(hsl_of_pixel(red, green, blue));
      taken_cnt++;
    end
  end

  initial begin : stimulus
    logic [23:0] corner_px [] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'hFF0001, 24'hFF0100, 24'h01FF00, 24'h0001FF, 24'hFF00FF,
      24'hFFFF00, 24'h00FFFF, 24'h010000, 24'h000001, 24'hFEFFFF, 24'hFF8001,
      24'hFFC864, 24'h80807F, 24'h7F8080, 24'hFF7F00, 24'h00FE01, 24'h55AA2B
    };
    int          rail_vals[6] = '{0, 1, 127, 128, 254, 255};
    int          ch[3];
    int          base, mx, k, t, gap_mode;
    pixel_req_t  px;

    foreach (corner_px[i]) begin
      px.r     = corner_px[i][23:16];
      px.g     = corner_px[i][15:8];
      px.b     = corner_px[i][7:0];
      px.gap   = $urandom_range(0, 3);
      px.drain = (i == corner_px.size() - 1);
      pixel_req_q.push_back(px);
    end

    gap_mode = 0;
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 50 == 0) gap_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        6: begin
          base = $urandom_range(0, 255);
          foreach (ch[j]) begin
            ch[j] = base + $urandom_range(0, 4) - 2;
            if (ch[j] < 0) ch[j] = 0;
            if (ch[j] > 255) ch[j] = 255;
          end
        end
        7: foreach (ch[j]) ch[j] = rail_vals[$urandom_range(0, 5)];
        8: begin
          ch[0] = $urandom_range(0, 255);
          ch[1] = ch[0];
          ch[2] = $urandom_range(0, 255);
        end
        9: begin
          // sum of max and min around the lightness midpoint
          mx    = $urandom_range(128, 255);
          ch[0] = mx;
          ch[1] = 255 - mx + $urandom_range(0, 1);
          ch[2] = $urandom_range(ch[1], mx);
        end
        default: foreach (ch[j]) ch[j] = $urandom_range(0, 255);
      endcase
      k = $urandom_range(0, 2);
      t = ch[0]; ch[0] = ch[k]; ch[k] = t;
      k = $urandom_range(1, 2);
      t = ch[1]; ch[1] = ch[k]; ch[k] = t;
      px.r     = CH_W'(ch[0]);
      px.g     = CH_W'(ch[1]);
      px.b     = CH_W'(ch[2]);
      px.gap   = (gap_mode == 0) ? 0 :
                 (gap_mode == 1) ? $urandom_range(0, 12) : $urandom_range(0, 2);
      px.drain = (i % 250 == 125);
      pixel_req_q.push_back(px);
    end

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    while (pixel_req_q.size() != 0 || start || hsl_due_q.size() != 0)
      @(posedge clk);
    repeat (2 * PIPE_DEPTH + 10) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("rgb_to_hsl_converter_core_test: done, clean");
    end else begin
      $display("rgb_to_hsl_converter_core_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("%0t: timeout", $realtime);
    $display("rgb_to_hsl_converter_core_test: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/rgbhsl_pkg.sv
rtl/rgb_to_hsl_converter_core.sv
test/rgb_to_hsl_converter_core_test.sv
